[hw/rtl/uns_pkg.sv]
// ----------------------------------------------------------------------------
// uns_pkg
// Shared widths, register indexes, character codes, note tables and the
// command/status bundles between the sequencer controller and datapath.
// ----------------------------------------------------------------------------
package uns_pkg;

    // Default receive buffer and song store depth
    localparam int BUF_LEN_DEF = 64;

    // Register widths
    localparam int OSC_W   = 26;
    localparam int PRE_W   = 7;
    localparam int TICK_W  = 16;
    localparam int RATIO_W = 8;
    localparam int CFG_W   = OSC_W;
    localparam int CFG_A_W = 2;

    // Field widths
    localparam int CHAR_W     = 8;
    localparam int PERIOD_W   = 8;
    localparam int DUTY_W     = 10;
    localparam int NOTE_POS_W = 6;
    localparam int SONG_LEN_W = 7;
    localparam int OUT_W      = 1 + PERIOD_W + DUTY_W + NOTE_POS_W + SONG_LEN_W;

    // Period divisor: 4 * freq * prescale
    localparam int FREQ_W = 10;
    localparam int DVS_W  = FREQ_W + PRE_W + 2;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_OSC_FREQ   = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_PRESCALE   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_NOTE_TICKS = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_DUTY_RATIO = 2'd3;

    // Register reset values
    localparam logic [OSC_W-1:0]   OSC_RST   = OSC_W'(16000000);
    localparam logic [PRE_W-1:0]   PRE_RST   = PRE_W'(64);
    localparam logic [TICK_W-1:0]  TICKS_RST = TICK_W'(2000);
    localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(128);

    // Input word kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Characters
    localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_UG = 8'h47;  // 'G'
    localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_LG = 8'h67;  // 'g'

    // Note frequencies in Hz
    localparam logic [FREQ_W-1:0] FREQ_C  = FREQ_W'(523);
    localparam logic [FREQ_W-1:0] FREQ_CS = FREQ_W'(554);
    localparam logic [FREQ_W-1:0] FREQ_D  = FREQ_W'(587);
    localparam logic [FREQ_W-1:0] FREQ_DS = FREQ_W'(622);
    localparam logic [FREQ_W-1:0] FREQ_E  = FREQ_W'(659);
    localparam logic [FREQ_W-1:0] FREQ_F  = FREQ_W'(698);
    localparam logic [FREQ_W-1:0] FREQ_FS = FREQ_W'(740);
    localparam logic [FREQ_W-1:0] FREQ_G  = FREQ_W'(784);
    localparam logic [FREQ_W-1:0] FREQ_GS = FREQ_W'(831);
    localparam logic [FREQ_W-1:0] FREQ_A  = FREQ_W'(880);
    localparam logic [FREQ_W-1:0] FREQ_AS = FREQ_W'(932);
    localparam logic [FREQ_W-1:0] FREQ_B  = FREQ_W'(988);

    // Controller to datapath commands
    typedef struct packed {
        logic take_item;   // register the accepted word
        logic copy_init;   // start line copy at entry 0
        logic copy_step;   // check one buffer entry
        logic clr_tick;    // restart note length count
        logic silence;     // stop the tone
        logic wrap_pos;    // wrap play position to song length
        logic load_div;    // register period divisor
        logic div_start;   // launch period division
        logic set_period;  // load period from quotient
        logic set_duty;    // load duty, tone on
        logic load_out;    // load result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic boundary;    // accepted word ends a note
        logic line_ready;  // a full line waits
        logic copy_end;    // line copy finishes this cycle
        logic song_empty;  // no notes in the song
        logic freq_zero;   // current entry is no note
        logic div_done;    // quotient ready
    } sts_t;

    // A-G naturals and a-g sharps
    function automatic logic note_letter(input logic [CHAR_W-1:0] c);
        note_letter = ((c >= CHAR_LA) && (c <= CHAR_LG)) ||
                      ((c >= CHAR_UA) && (c <= CHAR_UG));
    endfunction

    function automatic logic [FREQ_W-1:0] note_freq(input logic [CHAR_W-1:0] c);
        case (c)
            8'h41:   note_freq = FREQ_A;   // A
            8'h61:   note_freq = FREQ_AS;  // a
            8'h42:   note_freq = FREQ_B;   // B
            8'h62:   note_freq = FREQ_C;   // b plays as C
            8'h43:   note_freq = FREQ_C;   // C
            8'h63:   note_freq = FREQ_CS;  // c
            8'h44:   note_freq = FREQ_D;   // D
            8'h64:   note_freq = FREQ_DS;  // d
            8'h45:   note_freq = FREQ_E;   // E
            8'h65:   note_freq = FREQ_F;   // e plays as F
            8'h46:   note_freq = FREQ_F;   // F
            8'h66:   note_freq = FREQ_FS;  // f
            8'h47:   note_freq = FREQ_G;   // G
            8'h67:   note_freq = FREQ_GS;  // g
            default: note_freq = '0;
        endcase
    endfunction

endpackage

[hw/rtl/uart_note_sequencer_pwm.sv]
// ----------------------------------------------------------------------------
// uart_note_sequencer_pwm
// Serial-driven note sequencer producing PWM period and duty settings.
// ----------------------------------------------------------------------------
// One input word is taken at a time and yields one result word. A received
// byte or tick that does not end a note goes straight to the result load,
// which waits while the previous result still occupies the output. A word
// that ends a note first runs the note setup, including the restoring
// division of the oscillator frequency by 4*freq*prescale. When a complete
// line is pending at that point, the line copy first sweeps the receive
// buffer one entry per cycle, stopping at the first entry that is no note
// letter. A new word is accepted as soon as the controller is back in idle,
// even while the previous result still waits on the output.
module uart_note_sequencer_pwm
    import uns_pkg::*;
#(
    parameter int BUF_LEN = BUF_LEN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Input words
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic               s_axis_tuser,   // [0] action
    // Result words
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // [0] pwm_enable, [8:1] period_value,
                                               // [18:9] duty_value,
                                               // [24:19] note_position,
                                               // [31:25] song_length
    // Configuration
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    uns_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    uns_dp #(
        .BUF_LEN (BUF_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .action    (s_axis_tuser),
        .rx_byte   (s_axis_tdata),
        .out_word  (m_axis_tdata)
    );

endmodule

[hw/rtl/uns_div.sv]
// ----------------------------------------------------------------------------
// uns_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uns_div
    import uns_pkg::*;
#(
    parameter int DVD_W = OSC_W,
    parameter int DIV_W = DVS_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,    // held stable while busy
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVD_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   rem_sh;
    logic             fits;

    // Trial subtract
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DVD_W-1]};
        fits   = rem_sh >= {1'b0, divisor};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    // Shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= DIV_W'(rem_sh - {1'b0, divisor});
            end
            else
            begin
                rem_reg <= rem_sh[DIV_W-1:0];
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[hw/rtl/uns_dp.sv]
// ----------------------------------------------------------------------------
// uns_dp
// Sequencer datapath: receive buffer, song store, play state, config
// registers, period divisor and duty arithmetic, result register.
// ----------------------------------------------------------------------------
module uns_dp
    import uns_pkg::*;
#(
    parameter int BUF_LEN = BUF_LEN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               action,
    input  logic [CHAR_W-1:0]  rx_byte,
    output logic [OUT_W-1:0]   out_word
);

    localparam int IDX_W = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
    localparam int CNT_W = $clog2(BUF_LEN + 1);

    // Config registers
    logic [OSC_W-1:0]   osc_reg;
    logic [PRE_W-1:0]   pre_reg;
    logic [TICK_W-1:0]  ticks_reg;
    logic [RATIO_W-1:0] ratio_reg;

    // Play state
    logic [CNT_W-1:0]    rx_pos_reg;
    logic                line_ready_reg;
    logic [BUF_LEN-1:0]  rx_valid_reg;
    logic [CNT_W-1:0]    song_count_reg;
    logic [IDX_W-1:0]    play_pos_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic                pwm_on_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic [CNT_W-1:0]    copy_cnt_reg;
    logic [DVS_W-1:0]    div_reg;
    logic [OUT_W-1:0]    out_reg;

    // Memories
    logic [CHAR_W-1:0] rx_mem [BUF_LEN];
    logic [CHAR_W-1:0] song_mem [BUF_LEN];
    logic [CHAR_W-1:0] rx_rd_reg;
    logic              rx_rd_valid_reg;
    logic [CHAR_W-1:0] song_rd_reg;

    logic                  pos_wrap;
    logic [IDX_W-1:0]      wr_idx;
    logic                  line_ready_new;
    logic [TICK_W-1:0]     tick_next;
    logic                  tick_end;
    logic [CNT_W-1:0]      pp_inc;
    logic [IDX_W-1:0]      pp_next;
    logic [CHAR_W-1:0]     rx_char;
    logic                  letter;
    logic                  last;
    logic [CNT_W-1:0]      cnt_inc;
    logic [IDX_W-1:0]      rd_addr;
    logic                  finish;
    logic [FREQ_W-1:0]     freq;
    logic [PRE_W-1:0]      pre_eff;
    logic [FREQ_W+PRE_W-1:0] prod;
    logic [OSC_W-1:0]      quotient;
    logic                  div_done;
    logic [RATIO_W+PERIOD_W:0] duty_prod;

    uns_div #(
        .DVD_W (OSC_W),
        .DIV_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (osc_reg),
        .divisor  (div_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Word intake decode
    always_comb
    begin
        pos_wrap       = rx_pos_reg >= CNT_W'(BUF_LEN);
        wr_idx         = pos_wrap ? '0 : rx_pos_reg[IDX_W-1:0];
        line_ready_new = line_ready_reg | (rx_byte == CHAR_NL);
        tick_next      = tick_reg + TICK_W'(1);
        tick_end       = tick_next >= ticks_reg;
        pp_inc         = CNT_W'(play_pos_reg) + CNT_W'(1);
        pp_next        = (pp_inc >= song_count_reg) ? '0 : pp_inc[IDX_W-1:0];
    end

    // Line copy decode
    always_comb
    begin
        rx_char = rx_rd_valid_reg ? rx_rd_reg : '0;
        letter  = note_letter(rx_char);
        last    = copy_cnt_reg == CNT_W'(BUF_LEN - 1);
        cnt_inc = copy_cnt_reg + CNT_W'(1);
        finish  = cmd.copy_step && (!letter || last);
        if (cmd.copy_step && (cnt_inc < CNT_W'(BUF_LEN)))
        begin
            rd_addr = cnt_inc[IDX_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Period and duty arithmetic
    always_comb
    begin
        freq      = note_freq(song_rd_reg);
        pre_eff   = (pre_reg == '0) ? PRE_W'(1) : pre_reg;
        prod      = freq * pre_eff;
        duty_prod = ratio_reg * ({1'b0, period_reg} + (PERIOD_W + 1)'(1));
    end

    // Status
    always_comb
    begin
        sts.boundary   = (action == ACT_BYTE) ?
                         (line_ready_new && (song_count_reg == '0)) :
                         ((song_count_reg != '0) && tick_end);
        sts.line_ready = line_ready_reg;
        sts.copy_end   = !letter || last;
        sts.song_empty = song_count_reg == '0;
        sts.freq_zero  = freq == '0;
        sts.div_done   = div_done;
    end

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osc_reg   <= OSC_RST;
            pre_reg   <= PRE_RST;
            ticks_reg <= TICKS_RST;
            ratio_reg <= RATIO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_OSC_FREQ:   osc_reg   <= cfg_wdata[OSC_W-1:0];
                REG_PRESCALE:   pre_reg   <= cfg_wdata[PRE_W-1:0];
                REG_NOTE_TICKS: ticks_reg <= cfg_wdata[TICK_W-1:0];
                REG_DUTY_RATIO: ratio_reg <= cfg_wdata[RATIO_W-1:0];
                default:        ;
            endcase
        end
    end

    // Play state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_pos_reg     <= '0;
            line_ready_reg <= 1'b0;
            rx_valid_reg   <= '0;
            song_count_reg <= '0;
            play_pos_reg   <= '0;
            tick_reg       <= '0;
            pwm_on_reg     <= 1'b0;
            period_reg     <= '0;
            duty_reg       <= '0;
            copy_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.take_item)
            begin
                if (action == ACT_BYTE)
                begin
                    rx_valid_reg[wr_idx] <= 1'b1;
                    rx_pos_reg           <= CNT_W'(wr_idx) + CNT_W'(1);
                    line_ready_reg       <= line_ready_new;
                end
                else if (song_count_reg != '0)
                begin
                    tick_reg <= tick_next;
                    if (tick_end)
                    begin
                        play_pos_reg <= pp_next;
                    end
                end
            end
            if (cmd.copy_init)
            begin
                copy_cnt_reg <= '0;
            end
            if (cmd.copy_step && letter && !last)
            begin
                copy_cnt_reg <= cnt_inc;
            end
            // Line taken: song length fixed, buffer cleared, play from start
            if (finish)
            begin
                song_count_reg <= letter ? cnt_inc : copy_cnt_reg;
                rx_valid_reg   <= '0;
                rx_pos_reg     <= '0;
                play_pos_reg   <= '0;
                line_ready_reg <= 1'b0;
            end
            if (cmd.clr_tick)
            begin
                tick_reg <= '0;
            end
            if (cmd.wrap_pos && (CNT_W'(play_pos_reg) >= song_count_reg))
            begin
                play_pos_reg <= '0;
            end
            if (cmd.silence)
            begin
                pwm_on_reg <= 1'b0;
            end
            if (cmd.set_period)
            begin
                period_reg <= quotient[PERIOD_W-1:0] - PERIOD_W'(1);
            end
            if (cmd.set_duty)
            begin
                duty_reg   <= duty_prod[RATIO_W+PERIOD_W-1 -: DUTY_W];
                pwm_on_reg <= 1'b1;
            end
        end
    end

    // Divisor and result words
    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            div_reg <= {prod, 2'b00};
        end
        if (cmd.load_out)
        begin
            out_reg <= {SONG_LEN_W'(song_count_reg),
                        NOTE_POS_W'(play_pos_reg),
                        pwm_on_reg ? duty_reg : DUTY_W'(0),
                        pwm_on_reg ? period_reg : PERIOD_W'(0),
                        pwm_on_reg};
        end
    end

    // Receive buffer
    always_ff @(posedge clk)
    begin
        if (cmd.take_item && (action == ACT_BYTE))
        begin
            rx_mem[wr_idx] <= rx_byte;
        end
        rx_rd_reg       <= rx_mem[rd_addr];
        rx_rd_valid_reg <= rx_valid_reg[rd_addr];
    end

    // Song store
    always_ff @(posedge clk)
    begin
        if (cmd.copy_step && letter)
        begin
            song_mem[copy_cnt_reg[IDX_W-1:0]] <= rx_char;
        end
        song_rd_reg <= song_mem[play_pos_reg];
    end

    assign out_word = out_reg;

    // Buffer write pointer never runs past the end
    a_rx_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rx_pos_reg <= CNT_W'(BUF_LEN))
        else $error("receive position beyond buffer");

    // Copy sweep stays inside the buffer
    a_copy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_step |-> (copy_cnt_reg < CNT_W'(BUF_LEN)))
        else $error("copy sweep beyond buffer");

    // A tone starts only on a note inside the song
    a_tone_pos: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pwm_on_reg) |-> (CNT_W'(play_pos_reg) < song_count_reg))
        else $error("tone started outside the song");

endmodule

[hw/rtl/uns_ctrl.sv]
// ----------------------------------------------------------------------------
// uns_ctrl
// Sequencer controller: takes one word at a time, runs the line copy and the
// note setup on a boundary, and hands the result to the output register.
// ----------------------------------------------------------------------------
module uns_ctrl
    import uns_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BOUND  = 4'd1;
    localparam logic [3:0] S_CPY0   = 4'd2;
    localparam logic [3:0] S_COPY   = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_SREAD  = 4'd5;
    localparam logic [3:0] S_FREQ   = 4'd6;
    localparam logic [3:0] S_DIVGO  = 4'd7;
    localparam logic [3:0] S_DIVW   = 4'd8;
    localparam logic [3:0] S_PERIOD = 4'd9;
    localparam logic [3:0] S_DUTY   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = sts.boundary ? S_BOUND : S_OUT;
                end
            end
            S_BOUND:
            begin
                cmd.clr_tick = 1'b1;
                state_next   = sts.line_ready ? S_CPY0 : S_CHECK;
            end
            S_CPY0:
            begin
                cmd.copy_init = 1'b1;
                state_next    = S_COPY;
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (sts.copy_end)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.song_empty)
                begin
                    cmd.silence = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.wrap_pos = 1'b1;
                    state_next   = S_SREAD;
                end
            end
            S_SREAD:
            begin
                state_next = S_FREQ;
            end
            S_FREQ:
            begin
                if (sts.freq_zero)
                begin
                    cmd.silence = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.load_div = 1'b1;
                    state_next   = S_DIVGO;
                end
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (sts.div_done)
                begin
                    state_next = S_PERIOD;
                end
            end
            S_PERIOD:
            begin
                cmd.set_period = 1'b1;
                state_next     = S_DUTY;
            end
            S_DUTY:
            begin
                cmd.set_duty = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result word valid
    always_comb
    begin
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = m_tvalid_reg;

    // Quotient arrives only while the controller waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_DIVW))
        else $error("quotient outside divide wait");

    // An accepted word always leaves idle for processing
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != S_IDLE))
        else $error("accepted word not processed");

    // Copy runs only when a line was pending at the boundary
    a_copy_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CPY0) |-> $past(state_reg == S_BOUND && sts.line_ready))
        else $error("line copy without pending line");

endmodule
